/* sv/tbdpc_pkg.sv */
package tbdpc_pkg;

	// fixed field widths
	localparam int TICKS_W = 12;
	localparam int OCC_W = 16;
	localparam int WAIT_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int TICK_WIDTH_DEF = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 2'd2;

	// register reset values (625 ticks of 2.8 us is the 30 cm near distance)
	localparam logic [TICKS_W-1:0] NEAR_TICKS_RST = 12'd625;
	localparam logic [TICKS_W-1:0] MAX_TICKS_RST = 12'd1500;
	localparam logic [WAIT_W-1:0] WAIT_LIMIT_RST = 16'd30000;

	localparam logic signed [OCC_W-1:0] OCC_MAX = 16'sh7fff;
	localparam logic signed [OCC_W-1:0] OCC_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_MEASURE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		DIR_IDLE = 3'd0,
		DIR_B_SEEN = 3'd1,
		DIR_B_THEN_A = 3'd2,
		DIR_A_SEEN = 3'd3,
		DIR_A_THEN_B = 3'd4
	} dir_t;

	typedef struct packed {
		logic action;
		logic echo_a;
		logic echo_b;
	} in_t;

	typedef struct packed {
		logic signed [OCC_W-1:0] occupancy;
		logic [2:0] direction_state;
		logic timed_out;
		logic [TICKS_W-1:0] ticks_a;
		logic [TICKS_W-1:0] ticks_b;
	} out_t;

	typedef struct packed {
		logic [TICKS_W-1:0] near_ticks;
		logic [TICKS_W-1:0] max_ticks;
		logic [WAIT_W-1:0] wait_limit;
	} cfg_t;

endpackage

/* sv/tbdpc_core.sv */
module tbdpc_core
	import tbdpc_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic item_valid,
	input  in_t  item,
	input  logic step,
	output logic res_valid,
	output out_t res
);

	localparam int CW = TICK_WIDTH;
	localparam int WW = (CW > TICKS_W) ? CW : TICKS_W;
	localparam logic [WW-1:0] TMASK = WW'((1 << CW) - 1);

	phase_t phase_q, phase_n;
	logic [WAIT_W-1:0] wait_q, wait_n;
	logic [CW-1:0] cnt_a_q, cnt_a_n, cnt_b_q, cnt_b_n;
	dir_t dir_q, dir_n;
	logic signed [OCC_W-1:0] people_q, people_n;

	logic [WW-1:0] lim;
	logic [WW:0] inc_a, inc_b;
	logic sample, both_hi, any_hi, measuring, timeout, finish;
	logic near_a, near_b;

	assign sample = item.action;
	assign both_hi = item.echo_a & item.echo_b;
	assign any_hi = item.echo_a | item.echo_b;
	assign lim = (WW'(cfg.max_ticks) < TMASK) ? WW'(cfg.max_ticks) : TMASK;
	assign inc_a = (WW + 1)'(cnt_a_q) + 1'b1;
	assign inc_b = (WW + 1)'(cnt_b_q) + 1'b1;
	assign near_a = WW'(cnt_a_q) < WW'(cfg.near_ticks);
	assign near_b = WW'(cnt_b_q) < WW'(cfg.near_ticks);

	assign measuring = sample &&
		((phase_q == PH_WAIT && both_hi) || phase_q == PH_MEASURE);
	assign timeout = sample && phase_q == PH_WAIT && !both_hi &&
		wait_q >= cfg.wait_limit;
	assign finish = measuring && !any_hi;

	// ping phase, wait counter and echo counters
	always_comb begin
		phase_n = phase_q;
		wait_n = wait_q;
		cnt_a_n = cnt_a_q;
		cnt_b_n = cnt_b_q;
		if (!sample) begin
			phase_n = PH_WAIT;
			wait_n = '0;
			cnt_a_n = '0;
			cnt_b_n = '0;
		end else if (timeout) begin
			phase_n = PH_IDLE;
		end else if (phase_q == PH_WAIT && !both_hi) begin
			wait_n = wait_q + 1'b1;
		end else if (measuring) begin
			if (any_hi) begin
				phase_n = PH_MEASURE;
				if (item.echo_a)
					cnt_a_n = (inc_a > (WW + 1)'(lim)) ? CW'(lim) : CW'(inc_a);
				if (item.echo_b)
					cnt_b_n = (inc_b > (WW + 1)'(lim)) ? CW'(lim) : CW'(inc_b);
			end else begin
				phase_n = PH_IDLE;
			end
		end
	end

	// direction machine and occupancy, moved only when a measurement closes
	always_comb begin
		dir_n = dir_q;
		people_n = people_q;
		if (finish) begin
			if (near_a || near_b) begin
				unique case (dir_q)
					DIR_B_SEEN: if (near_a) dir_n = DIR_B_THEN_A;
					DIR_B_THEN_A: dir_n = DIR_B_THEN_A;
					DIR_A_SEEN: if (near_b) dir_n = DIR_A_THEN_B;
					DIR_A_THEN_B: dir_n = DIR_A_THEN_B;
					default: dir_n = near_b ? DIR_B_SEEN : DIR_A_SEEN;
				endcase
			end else begin
				if (dir_q == DIR_B_THEN_A && people_q != OCC_MAX)
					people_n = people_q + 16'sd1;
				else if (dir_q == DIR_A_THEN_B && people_q != OCC_MIN)
					people_n = people_q - 16'sd1;
				dir_n = DIR_IDLE;
			end
		end
	end

	// result beat
	always_comb begin
		res_valid = item_valid && (timeout || finish);
		res.occupancy = people_n;
		res.direction_state = dir_n;
		res.timed_out = timeout;
		res.ticks_a = timeout ? '0 : TICKS_W'(WW'(cnt_a_q));
		res.ticks_b = timeout ? '0 : TICKS_W'(WW'(cnt_b_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			dir_q <= DIR_IDLE;
			people_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			wait_q <= wait_n;
			cnt_a_q <= cnt_a_n;
			cnt_b_q <= cnt_b_n;
			dir_q <= dir_n;
			people_q <= people_n;
		end
	end

	a_ping_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.action |=> phase_q == PH_WAIT && wait_q == '0)
		else $error("ping did not restart the wait phase");

	a_result_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> phase_q == PH_IDLE)
		else $error("phase not idle after a result");

	a_people_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		people_q != $past(people_q) |-> $past(step) && $past(res_valid) &&
			!$past(res.timed_out))
		else $error("occupancy moved without a measurement result");

endmodule

/* sv/tbdpc_out_reg.sv */
module tbdpc_out_reg
	import tbdpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  out_t load_data,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic valid_q;
	out_t data_q;

	assign free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

/* sv/two_beam_direction_people_counter.sv */
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// input     | in_valid / in_ready        | in_data: action, echo_a, echo_b
// result    | out_valid / out_ready      | out_data: occupancy, direction_state,
//           |                            |   timed_out, ticks_a, ticks_b
// config    | cfg_we (no wait)           | cfg_index, cfg_data
//
// one input beat per cycle while in_ready stays high; a result passes the input register,
// then the state update loads it into the output register
// reset clears all control state and loads the register defaults, no clearing pass
// in_ready falls only when the input register holds a beat that makes a result
// and the output register is full and not being taken
module two_beam_direction_people_counter
	import tbdpc_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	cfg_t cfg_q;

	// input register
	logic vld_s1;
	in_t data_s1;

	// core hookup
	logic res_valid;
	out_t res;
	logic free;
	logic fire;

	// the beat in the input register moves on when it makes no result,
	// or when the output register has room for the one it makes
	assign fire = vld_s1 && (!res_valid || free);
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_ticks <= NEAR_TICKS_RST;
			cfg_q.max_ticks <= MAX_TICKS_RST;
			cfg_q.wait_limit <= WAIT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEAR_TICKS: cfg_q.near_ticks <= cfg_data[TICKS_W-1:0];
				CFG_MAX_TICKS: cfg_q.max_ticks <= cfg_data[TICKS_W-1:0];
				CFG_WAIT_LIMIT: cfg_q.wait_limit <= cfg_data[WAIT_W-1:0];
				default: cfg_q <= cfg_q; // unused index, write ignored
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	tbdpc_core #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(vld_s1),
		.item(data_s1),
		.step(fire),
		.res_valid(res_valid),
		.res(res)
	);

	tbdpc_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(fire && res_valid),
		.load_data(res),
		.free(free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
